// File: rtl/core/two_step_line_rasterizer_defines.svh
// Assertion macros for the two-step line rasterizer.
// Included by files that assert; relies on clk and arst_n in the including module.
`ifndef TWO_STEP_LINE_RASTERIZER_DEFINES_SVH
`define TWO_STEP_LINE_RASTERIZER_DEFINES_SVH

// Checked only while out of reset.
`define TSLR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TSLR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tslr_pkg.sv
// Types, widths and helpers for the two-step line rasterizer.
// No dependencies.
package tslr_pkg;

	localparam int COORD_BITS = 10;
	localparam int DEC_W      = COORD_BITS + 5;
	localparam int THR_W      = COORD_BITS + 4;
	localparam int STEPS_W    = COORD_BITS - 2;
	localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int BATCH_MAX  = 4;
	localparam int CNT_W      = 3;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LOOP = 2'd1;
	localparam logic [1:0] PH_LEFT = 2'd2;

	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic   line_done;
		logic   run_last;
		coord_t py;
		coord_t px;
	} point_t;

	// Move a coordinate by k units in the given direction.
	function automatic coord_t move(coord_t c, logic neg, logic [1:0] k);
		coord_t kk;
		kk = COORD_BITS'(k);
		return neg ? coord_t'(c - kk) : coord_t'(c + kk);
	endfunction

	// Map major/minor coordinates back to x/y.
	function automatic point_t mk_point(logic xm, coord_t a, coord_t b, logic last,
		logic done);
		point_t p;
		p.px        = xm ? a : b;
		p.py        = xm ? b : a;
		p.run_last  = last;
		p.line_done = done;
		return p;
	endfunction

endpackage

// File: rtl/core/two_step_line_rasterizer.sv
// Two-step line rasterizer: draws from both ends toward the middle, four points a step.
// Depends on tslr_pkg and two_step_line_rasterizer_defines.svh.
//
// Channel  Dir  Payload                                  Marker
// s_axis   in   tdata: x_start, y_start, x_end, y_end    tuser: action
// m_axis   out  tdata: px, py                            tlast: run_last, tuser: line_done
//
// An accepted item is held in the input register until it advances, then its whole batch of
// up to four points is computed in one pass into the point buffer.
// The buffer drains one point per cycle while m_tready is high. An item yields no points
// for a step while idle, 1 or 2 for a start, 4 for a loop step, 1 to 3 for leftovers.
// The next batch loads in the cycle the last buffered point is taken, without a bubble.
// Reset clears all control state; m_tready low holds the buffer and backs up s_tready.
`include "two_step_line_rasterizer_defines.svh"

module two_step_line_rasterizer import tslr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // x_start, y_start, x_end, y_end
	input  logic                  s_tuser,   // action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // px, py, zero fill
	output logic                  m_tlast,
	output logic                  m_tuser    // line_done
);

	// input register
	logic   vld_s1, act_s1;
	coord_t xs_s1, ys_s1, xe_s1, ye_s1;

	// line state in major/minor form
	coord_t                    na_q, nb_q, fa_q, fb_q;
	logic                      aneg_q, bneg_q, xmaj_q, shallow_q;
	logic signed [DEC_W-1:0]   dec_q;
	logic signed [THR_W-1:0]   thr_q;
	logic signed [DEC_W-1:0]   inc1_q, inc2_q;
	logic [STEPS_W-1:0]        steps_q;
	logic [1:0]                left_q;
	logic [1:0]                phase_q;

	// point buffer
	point_t             pts_q [BATCH_MAX];
	logic [CNT_W-1:0]   cnt_q;

	logic advance, out_take;

	assign out_take = m_tvalid && m_tready;
	assign advance  = vld_s1 && ((cnt_q == '0) || ((cnt_q == CNT_W'(1)) && m_tready));
	assign s_tready = !vld_s1 || advance;

	// next-state values
	coord_t                    na_d, nb_d, fa_d, fb_d;
	logic                      aneg_d, bneg_d, xmaj_d, shallow_d;
	logic signed [DEC_W-1:0]   dec_d;
	logic signed [THR_W-1:0]   thr_d;
	logic signed [DEC_W-1:0]   inc1_d, inc2_d;
	logic [STEPS_W-1:0]        steps_d;
	logic [1:0]                left_d;
	logic [1:0]                phase_d;
	point_t                    pts_d [BATCH_MAX];
	logic [CNT_W-1:0]          cnt_d;

	// start math
	coord_t                    adx, ady, da, db, dam1;
	logic                      xneg, yneg, xm;
	logic signed [DEC_W-1:0]   da_e, db_e, thr_e, i2;
	logic signed [THR_W-1:0]   thr_n;
	logic [STEPS_W-1:0]        st_n;
	logic [1:0]                lf_n, ph_n;

	// step math
	logic                      first, m1, m2, n1, n2, n3;
	logic [1:0]                msum, nsum;
	logic signed [DEC_W-1:0]   thr_x;
	logic [STEPS_W-1:0]        st_dec;
	logic [1:0]                ph_loop;

	always_comb begin
		na_d = na_q; nb_d = nb_q; fa_d = fa_q; fb_d = fb_q;
		aneg_d = aneg_q; bneg_d = bneg_q; xmaj_d = xmaj_q; shallow_d = shallow_q;
		dec_d = dec_q; thr_d = thr_q; inc1_d = inc1_q; inc2_d = inc2_q;
		steps_d = steps_q; left_d = left_q; phase_d = phase_q;
		for (int i = 0; i < BATCH_MAX; i++) begin
			pts_d[i] = pts_q[i];
		end
		cnt_d = '0;

		xneg = xe_s1 < xs_s1;
		yneg = ye_s1 < ys_s1;
		adx  = xneg ? coord_t'(xs_s1 - xe_s1) : coord_t'(xe_s1 - xs_s1);
		ady  = yneg ? coord_t'(ys_s1 - ye_s1) : coord_t'(ye_s1 - ys_s1);
		xm   = adx > ady;
		da   = xm ? adx : ady;
		db   = xm ? ady : adx;
		dam1 = coord_t'(da - coord_t'(1));
		st_n = dam1[COORD_BITS-1:2];
		lf_n = dam1[1:0];
		da_e = DEC_W'(da);
		db_e = DEC_W'(db);
		i2   = (db_e <<< 2) - (da_e <<< 1);
		thr_e = (i2 < 0) ? (db_e <<< 1) : ((db_e - da_e) <<< 1);
		thr_n = thr_e[THR_W-1:0];
		if (st_n != '0) begin
			ph_n = PH_LOOP;
		end else if (lf_n != 2'd0) begin
			ph_n = PH_LEFT;
		end else begin
			ph_n = PH_IDLE;
		end

		thr_x = {{(DEC_W-THR_W){thr_q[THR_W-1]}}, thr_q};
		first = shallow_q ? (dec_q < 0) : (dec_q > 0);
		if (first) begin
			m1 = !shallow_q;
			m2 = !shallow_q;
			n1 = !shallow_q; n2 = !shallow_q; n3 = !shallow_q;
		end else if (dec_q < thr_x) begin
			m1 = 1'b0; m2 = 1'b1;
			n1 = 1'b0; n2 = 1'b1; n3 = 1'b0;
		end else begin
			m1 = 1'b1; m2 = 1'b0;
			n1 = 1'b1; n2 = 1'b0; n3 = shallow_q || (dec_q > thr_x);
		end
		msum    = {1'b0, m1} + {1'b0, m2};
		nsum    = {1'b0, n1} + {1'b0, n2};
		st_dec  = steps_q - STEPS_W'(1);
		ph_loop = (st_dec != '0) ? PH_LOOP : ((left_q != 2'd0) ? PH_LEFT : PH_IDLE);

		if (act_s1 == ACT_START) begin
			xmaj_d = xm;
			aneg_d = xm ? xneg : yneg;
			bneg_d = xm ? yneg : xneg;
			na_d = xm ? xs_s1 : ys_s1;
			nb_d = xm ? ys_s1 : xs_s1;
			fa_d = xm ? xe_s1 : ye_s1;
			fb_d = xm ? ye_s1 : xe_s1;
			if (da == '0) begin
				// equal endpoints: a single point closes the line
				phase_d = PH_IDLE;
				steps_d = '0;
				left_d  = 2'd0;
				pts_d[0] = mk_point(1'b0, ys_s1, xs_s1, 1'b1, 1'b1);
				cnt_d = CNT_W'(1);
			end else begin
				steps_d   = st_n;
				left_d    = lf_n;
				inc2_d    = i2;
				shallow_d = i2 < 0;
				thr_d     = thr_n;
				inc1_d    = thr_e <<< 1;
				dec_d     = (i2 < 0) ? ((thr_e <<< 1) - da_e) : ((thr_e <<< 1) + da_e);
				phase_d   = ph_n;
				pts_d[0] = mk_point(xm, xm ? xs_s1 : ys_s1, xm ? ys_s1 : xs_s1, 1'b0, 1'b0);
				pts_d[1] = mk_point(xm, xm ? xe_s1 : ye_s1, xm ? ye_s1 : xe_s1, 1'b1,
					ph_n == PH_IDLE);
				cnt_d = CNT_W'(2);
			end
		end else begin
			unique case (phase_q)
				PH_LOOP: begin
					dec_d   = dec_q + (first ? inc1_q : inc2_q);
					steps_d = st_dec;
					phase_d = ph_loop;
					na_d = move(na_q, aneg_q, 2'd2);
					nb_d = move(nb_q, bneg_q, msum);
					fa_d = move(fa_q, !aneg_q, 2'd2);
					fb_d = move(fb_q, !bneg_q, msum);
					pts_d[0] = mk_point(xmaj_q, move(na_q, aneg_q, 2'd1),
						move(nb_q, bneg_q, {1'b0, m1}), 1'b0, 1'b0);
					pts_d[1] = mk_point(xmaj_q, move(na_q, aneg_q, 2'd2),
						move(nb_q, bneg_q, msum), 1'b0, 1'b0);
					pts_d[2] = mk_point(xmaj_q, move(fa_q, !aneg_q, 2'd1),
						move(fb_q, !bneg_q, {1'b0, m1}), 1'b0, 1'b0);
					pts_d[3] = mk_point(xmaj_q, move(fa_q, !aneg_q, 2'd2),
						move(fb_q, !bneg_q, msum), 1'b1, ph_loop == PH_IDLE);
					cnt_d = CNT_W'(4);
				end
				PH_LEFT: begin
					// end positions are not read again before the next start
					phase_d = PH_IDLE;
					left_d  = 2'd0;
					pts_d[0] = mk_point(xmaj_q, move(na_q, aneg_q, 2'd1),
						move(nb_q, bneg_q, {1'b0, n1}), left_q == 2'd1, left_q == 2'd1);
					pts_d[1] = mk_point(xmaj_q, move(na_q, aneg_q, 2'd2),
						move(nb_q, bneg_q, nsum), left_q == 2'd2, left_q == 2'd2);
					pts_d[2] = mk_point(xmaj_q, move(fa_q, !aneg_q, 2'd1),
						move(fb_q, !bneg_q, {1'b0, n3}), 1'b1, 1'b1);
					cnt_d = CNT_W'(left_q);
				end
				default: begin
					// step while idle: drop it
					cnt_d = '0;
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			act_s1 <= s_tuser;
			xs_s1  <= s_tdata[COORD_BITS-1:0];
			ys_s1  <= s_tdata[2*COORD_BITS-1:COORD_BITS];
			xe_s1  <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];
			ye_s1  <= s_tdata[4*COORD_BITS-1:3*COORD_BITS];
		end
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			na_q <= '0; nb_q <= '0; fa_q <= '0; fb_q <= '0;
			aneg_q <= 1'b0; bneg_q <= 1'b0; xmaj_q <= 1'b0; shallow_q <= 1'b0;
			dec_q <= '0; thr_q <= '0; inc1_q <= '0; inc2_q <= '0;
			steps_q <= '0; left_q <= 2'd0; phase_q <= PH_IDLE;
		end else if (advance) begin
			na_q <= na_d; nb_q <= nb_d; fa_q <= fa_d; fb_q <= fb_d;
			aneg_q <= aneg_d; bneg_q <= bneg_d; xmaj_q <= xmaj_d; shallow_q <= shallow_d;
			dec_q <= dec_d; thr_q <= thr_d; inc1_q <= inc1_d; inc2_q <= inc2_d;
			steps_q <= steps_d; left_q <= left_d; phase_q <= phase_d;
		end
	end

	// point buffer: load a batch or shift one point out per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= cnt_d;
		end else if (out_take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < BATCH_MAX; i++) begin
				pts_q[i] <= pts_d[i];
			end
		end else if (out_take) begin
			for (int i = 0; i < BATCH_MAX - 1; i++) begin
				pts_q[i] <= pts_q[i+1];
			end
		end
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = OUT_DATA_W'({pts_q[0].py, pts_q[0].px});
	assign m_tlast  = pts_q[0].run_last;
	assign m_tuser  = pts_q[0].line_done;

	`TSLR_ASSERT(a_cnt_range, cnt_q <= CNT_W'(BATCH_MAX), "point buffer overfilled")
	`TSLR_ASSERT(a_batch_end, m_tvalid && (cnt_q == CNT_W'(1)) |-> m_tlast,
		"final buffered point lacks run_last")
	`TSLR_ASSERT(a_done_last, m_tvalid && m_tuser |-> m_tlast, "line_done without run_last")
	`TSLR_ASSERT(a_loop_steps, phase_q == PH_LOOP |-> steps_q != '0,
		"loop phase with no steps left")
	`TSLR_ASSERT(a_drain_hold, m_tvalid && !m_tready |=> cnt_q == $past(cnt_q),
		"point buffer changed while stalled")
	`TSLR_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !m_tvalid, "output valid in reset")

endmodule
